FILE: src/sst_pkg.sv
// sparse set table package: widths, request and status codes, payload types
// no dependencies
package sst_pkg;

    localparam int INDEX_BITS = 12;
    localparam int MAP_DEPTH  = 1 << INDEX_BITS;
    localparam int CAPACITY   = 1024;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_BITS = 32;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_ADD_IF = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_GET    = 3'd3;
    localparam logic [2:0] REQ_SET    = 3'd4;
    localparam logic [2:0] REQ_SWAP   = 3'd5;
    localparam logic [2:0] REQ_READ   = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ABSENT  = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] entity;
        logic [31:0] entity_second;
        logic [31:0] value;
        logic [9:0]  position;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  dense_index;
        logic [31:0] value_out;
        logic [31:0] entity_out;
        logic [10:0] live_entries;
    } t_rsp;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_map_entry;

    typedef struct packed {
        logic [31:0]           handle;
        logic [VALUE_BITS-1:0] value;
    } t_dense_entry;

endpackage

FILE: src/sst_if.sv
// valid/ready channel interfaces for requests and responses
// depends on sst_pkg
interface sst_req_if;
    logic          valid;
    logic          ready;
    sst_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sst_rsp_if;
    logic          valid;
    logic          ready;
    sst_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/sparse_set_table_core.sv
// sparse set table core: slot map memory, dense handle/value memory, sequencer
// depends on sst_pkg and sst_if
//
// usage:
//   i_req carries one request per transfer (valid/ready), o_rsp one response
//   per request, in order.
//   the slot map (4096 entries) and dense array (1024 entries) are
//   synchronous memories with one read and one write port and a registered read.
//   after reset the map is swept to empty, with i_req.ready low.
//   after a request transfer every request passes S_M1 and S_M2, which hold the
//   dependent map read and dense read, and then S_OUT, which loads the response;
//   a remove of a present entity adds S_R3, and S_R4 when the last entry moves;
//   a swap of two present entities adds the write-back states S_W3 and S_W4.
//   one request is in flight at a time; the next is taken in the cycle after
//   the response is loaded.
//   a new request is taken while the previous response waits in the output register.
//   if o_rsp stalls, a finished response waits in the sequencer and no
//   further request is taken until the output register frees.
module sparse_set_table_core (
    input logic        i_clk,
    input logic        i_rst_n,
    sst_req_if.sink    i_req,
    sst_rsp_if.source  o_rsp
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_R3   = 4'd4;
    localparam logic [3:0] S_R4   = 4'd5;
    localparam logic [3:0] S_W3   = 4'd6;
    localparam logic [3:0] S_W4   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam int IB = sst_pkg::INDEX_BITS;
    localparam int SW = sst_pkg::SLOT_W;
    localparam int CW = sst_pkg::CNT_W;
    localparam int VB = sst_pkg::VALUE_BITS;

    sst_pkg::t_map_entry   map_mem [sst_pkg::MAP_DEPTH];
    sst_pkg::t_dense_entry dense_mem [sst_pkg::CAPACITY];

    logic [3:0]   r_state, n_state;
    logic [IB-1:0] r_clr;
    sst_pkg::t_req r_req;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_j1, r_j2;
    logic [31:0]   r_lasth;
    sst_pkg::t_dense_entry r_d1;
    logic [2:0]    r_st;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_val, r_ent;
    logic          r_ovalid;
    sst_pkg::t_rsp r_rsp;
    // first entity present, held from the map read
    logic          r_here1;

    sst_pkg::t_map_entry   map_q, map_wd;
    sst_pkg::t_dense_entry dense_q, dense_wd;
    logic [IB-1:0] map_ra, map_wa;
    logic          map_we;
    logic [SW-1:0] dense_ra, dense_wa;
    logic          dense_we;

    logic          here1, here2, full, moved;
    logic [SW-1:0] last;
    logic [IB-1:0] i1, i2;
    logic [VB-1:0] val_in;

    assign i1     = r_req.entity[IB-1:0];
    assign i2     = r_req.entity_second[IB-1:0];
    assign val_in = r_req.value[VB-1:0];
    assign here1  = map_q.valid && ({1'b0, map_q.slot} < r_count);
    assign here2  = map_q.valid && ({1'b0, map_q.slot} < r_count);
    assign full   = (r_count >= CW'(sst_pkg::CAPACITY));
    assign last   = SW'(r_count - CW'(1));
    assign moved  = (r_j1 != last);

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        map_q <= map_mem[map_ra];
        if (dense_we) dense_mem[dense_wa] <= dense_wd;
        dense_q <= dense_mem[dense_ra];
    end

    always_comb begin
        n_state  = r_state;
        map_ra   = i_req.payload.entity[IB-1:0];
        map_wa   = i1;
        map_wd   = '0;
        map_we   = 1'b0;
        dense_ra = r_j1;
        dense_wa = r_j1;
        dense_wd = dense_q;
        dense_we = 1'b0;
        case (r_state)
            S_CLR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                if (r_clr == {IB{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_M1;
            end
            S_M1: begin
                map_ra   = i2;
                dense_ra = (r_req.req_type == sst_pkg::REQ_READ) ? r_req.position[SW-1:0]
                                                                   : map_q.slot;
                n_state  = S_M2;
            end
            S_M2: begin
                n_state = S_OUT;
                case (r_req.req_type)
                    sst_pkg::REQ_ADD, sst_pkg::REQ_ADD_IF: begin
                        if (!r_here1 && !full) begin
                            map_we   = 1'b1;
                            map_wd   = '{valid: 1'b1, slot: SW'(r_count)};
                            dense_we = 1'b1;
                            dense_wa = SW'(r_count);
                            dense_wd = '{handle: r_req.entity, value: val_in};
                        end
                    end
                    sst_pkg::REQ_SET: begin
                        if (r_here1) begin
                            dense_we = 1'b1;
                            dense_wd = '{handle: dense_q.handle, value: val_in};
                        end
                    end
                    sst_pkg::REQ_REMOVE: begin
                        if (r_here1) begin
                            dense_ra = last;
                            n_state  = S_R3;
                        end
                    end
                    sst_pkg::REQ_SWAP: begin
                        if (r_here1 && here2) begin
                            dense_ra = map_q.slot;
                            n_state  = S_W3;
                        end
                    end
                    default: ;
                endcase
            end
            S_R3: begin
                map_we = 1'b1;
                if (moved) begin
                    dense_we = 1'b1;
                    dense_wd = dense_q;
                    n_state  = S_R4;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_R4: begin
                map_we  = 1'b1;
                map_wa  = r_lasth[IB-1:0];
                map_wd  = '{valid: 1'b1, slot: r_j1};
                n_state = S_OUT;
            end
            S_W3: begin
                dense_we = 1'b1;
                dense_wd = dense_q;
                map_we   = 1'b1;
                map_wd   = '{valid: 1'b1, slot: r_j2};
                n_state  = S_W4;
            end
            S_W4: begin
                dense_we = 1'b1;
                dense_wa = r_j2;
                dense_wd = r_d1;
                map_we   = 1'b1;
                map_wa   = i2;
                map_wd   = '{valid: 1'b1, slot: r_j1};
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + IB'(1);
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) r_req <= i_req.payload;
                end
                S_M1: begin
                    r_here1 <= here1;
                    r_j1    <= map_q.slot;
                end
                S_M2: begin
                    r_d1   <= dense_q;
                    r_j2   <= map_q.slot;
                    r_st   <= sst_pkg::ST_OK;
                    r_slot <= '0;
                    r_val  <= '0;
                    r_ent  <= '0;
                    case (r_req.req_type)
                        sst_pkg::REQ_ADD, sst_pkg::REQ_ADD_IF: begin
                            if (r_here1) begin
                                r_st   <= (r_req.req_type == sst_pkg::REQ_ADD)
                                          ? sst_pkg::ST_PRESENT : sst_pkg::ST_OK;
                                r_slot <= r_j1;
                                r_val  <= 32'(dense_q.value);
                                r_ent  <= dense_q.handle;
                            end else if (full) begin
                                r_st <= sst_pkg::ST_FULL;
                            end else begin
                                r_slot  <= SW'(r_count);
                                r_val   <= 32'(val_in);
                                r_ent   <= r_req.entity;
                                r_count <= r_count + CW'(1);
                            end
                        end
                        sst_pkg::REQ_GET, sst_pkg::REQ_SET: begin
                            if (r_here1) begin
                                r_slot <= r_j1;
                                r_val  <= (r_req.req_type == sst_pkg::REQ_SET)
                                          ? 32'(val_in) : 32'(dense_q.value);
                                r_ent  <= dense_q.handle;
                            end else begin
                                r_st <= sst_pkg::ST_ABSENT;
                            end
                        end
                        sst_pkg::REQ_REMOVE: begin
                            if (r_here1) begin
                                r_slot <= r_j1;
                                r_val  <= 32'(dense_q.value);
                                r_ent  <= dense_q.handle;
                            end else begin
                                r_st <= sst_pkg::ST_ABSENT;
                            end
                        end
                        sst_pkg::REQ_SWAP: begin
                            if (r_here1 && here2) begin
                                r_slot <= map_q.slot;
                                r_val  <= 32'(dense_q.value);
                                r_ent  <= dense_q.handle;
                            end else begin
                                r_st <= sst_pkg::ST_ABSENT;
                            end
                        end
                        sst_pkg::REQ_READ: begin
                            if ({1'b0, r_req.position} < r_count) begin
                                r_slot <= r_req.position[SW-1:0];
                                r_val  <= 32'(dense_q.value);
                                r_ent  <= dense_q.handle;
                            end else begin
                                r_st <= sst_pkg::ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
                S_R3: begin
                    r_lasth <= dense_q.handle;
                    r_count <= r_count - CW'(1);
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_rsp    <= '{status: r_st, dense_index: 10'(r_slot),
                                      value_out: r_val, entity_out: r_ent,
                                      live_entries: 11'(r_count)};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: verif/sparse_set_table_core_tb.sv
// testbench for sparse_set_table_core: directed and random table requests
// checked against a behavioral sparse-set predictor; depends on sst_pkg, sst_if
module sparse_set_table_core_tb;
    import sst_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sst_req_if req_ch ();
    sst_rsp_if rsp_ch ();

    sparse_set_table_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // predictor state
    bit          map_live [MAP_DEPTH];
    bit [10:0]   map_slot [MAP_DEPTH];
    bit [31:0]   slot_handle [CAPACITY];
    bit [31:0]   slot_value [CAPACITY];
    int unsigned live_count;

    t_rsp expected_rsps[$];
    int   mismatch_count;
    bit   hold_rsp;
    logic [31:0] known_handles[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit is_present(logic [31:0] h);
        int unsigned ix;
        ix = h[INDEX_BITS-1:0];
        return map_live[ix] && map_slot[ix] < live_count;
    endfunction

    function automatic t_rsp table_result(logic [2:0] st, int unsigned slot, bit show);
        t_rsp r;
        r = '0;
        r.status = st;
        if (show) begin
            r.dense_index = slot[9:0];
            r.value_out   = slot_value[slot];
            r.entity_out  = slot_handle[slot];
        end
        r.live_entries = live_count[10:0];
        return r;
    endfunction

    function automatic t_rsp apply_request(t_req q);
        int unsigned i1, i2, j1, j2, last;
        bit here, here2;
        logic [31:0] th, tv;
        t_rsp r;
        i1 = q.entity[INDEX_BITS-1:0];
        i2 = q.entity_second[INDEX_BITS-1:0];
        here = is_present(q.entity);
        j1 = here ? map_slot[i1] : 0;
        case (q.req_type)
            REQ_ADD, REQ_ADD_IF: begin
                if (here) begin
                    r = table_result(q.req_type == REQ_ADD ? ST_PRESENT : ST_OK, j1, 1);
                end else if (live_count >= CAPACITY) begin
                    r = table_result(ST_FULL, 0, 0);
                end else begin
                    map_live[i1] = 1;
                    map_slot[i1] = 11'(live_count);
                    slot_handle[live_count] = q.entity;
                    slot_value[live_count] = q.value;
                    live_count++;
                    r = table_result(ST_OK, live_count - 1, 1);
                end
            end
            REQ_REMOVE: begin
                if (!here) begin
                    r = table_result(ST_ABSENT, 0, 0);
                end else begin
                    last = live_count - 1;
                    r = table_result(ST_OK, j1, 1);
                    if (j1 != last) begin
                        slot_handle[j1] = slot_handle[last];
                        slot_value[j1] = slot_value[last];
                        map_slot[slot_handle[last][INDEX_BITS-1:0]] = 11'(j1);
                    end
                    map_live[i1] = 0;
                    map_slot[i1] = 0;
                    live_count = last;
                    r.live_entries = live_count[10:0];
                end
            end
            REQ_GET: r = here ? table_result(ST_OK, j1, 1) : table_result(ST_ABSENT, 0, 0);
            REQ_SET: begin
                if (here) begin
                    slot_value[j1] = q.value;
                    r = table_result(ST_OK, j1, 1);
                end else begin
                    r = table_result(ST_ABSENT, 0, 0);
                end
            end
            REQ_SWAP: begin
                here2 = is_present(q.entity_second);
                if (!here || !here2) begin
                    r = table_result(ST_ABSENT, 0, 0);
                end else begin
                    j2 = map_slot[i2];
                    th = slot_handle[j1];
                    tv = slot_value[j1];
                    slot_handle[j1] = slot_handle[j2];
                    slot_value[j1] = slot_value[j2];
                    slot_handle[j2] = th;
                    slot_value[j2] = tv;
                    map_slot[i1] = 11'(j2);
                    map_slot[i2] = 11'(j1);
                    r = table_result(ST_OK, j2, 1);
                end
            end
            REQ_READ: begin
                if (q.position < live_count)
                    r = table_result(ST_OK, q.position, 1);
                else
                    r = table_result(ST_RANGE, 0, 0);
            end
            default: r = table_result(ST_OK, 0, 0);
        endcase
        return r;
    endfunction

    // one request transfer; a following call keeps valid high without a gap
    task automatic send_request(t_req q);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_rsps.push_back(apply_request(q));
        if (q.req_type inside {REQ_ADD, REQ_ADD_IF}) known_handles.push_back(q.entity);
    endtask

    task automatic idle_request(int unsigned n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [2:0] op, logic [31:0] e, logic [31:0] e2,
                                      logic [31:0] v, logic [9:0] p);
        t_req q;
        q.req_type = op; q.entity = e; q.entity_second = e2; q.value = v; q.position = p;
        return q;
    endfunction

    function automatic logic [31:0] pick_handle();
        if (known_handles.size() == 0 || $urandom_range(0, 5) == 0) return $urandom();
        return known_handles[$urandom_range(0, known_handles.size() - 1)];
    endfunction

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(make_req(REQ_GET, 32'h0, 0, 0, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 10'd0));
        send_request(make_req(REQ_REMOVE, 32'h5, 0, 0, 0));
        send_request(make_req(REQ_ADD, 32'h0000_0000, 0, 32'h0, 0));
        send_request(make_req(REQ_ADD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
        send_request(make_req(REQ_ADD, 32'h1234_5FFF, 0, 32'h1, 0));
        send_request(make_req(REQ_ADD_IF, 32'h0000_0FFF, 0, 32'h2, 0));
        send_request(make_req(REQ_ADD_IF, 32'hAAAA_A123, 0, 32'h5555_5555, 0));
        send_request(make_req(REQ_SET, 32'h0000_0123, 0, 32'hDEAD_BEEF, 0));
        send_request(make_req(REQ_SET, 32'h0000_0777, 0, 32'h1, 0));
        send_request(make_req(REQ_SWAP, 32'h0, 32'h123, 0, 0));
        send_request(make_req(REQ_SWAP, 32'h0, 32'h777, 0, 0));
        send_request(make_req(REQ_SWAP, 32'h123, 32'hF123, 0, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 10'd2));
        send_request(make_req(REQ_READ, 0, 0, 0, 10'd3));
        send_request(make_req(REQ_READ, 0, 0, 0, 10'h3FF));
        send_request(make_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));
        send_request(make_req(REQ_REMOVE, 32'h0, 0, 0, 0));
        send_request(make_req(REQ_REMOVE, 32'h0000_0123, 0, 0, 0));
        send_request(make_req(REQ_GET, 32'hFFFF_0FFF, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_fill_table();
        int unsigned k, fill_n;
        // fill a block of entries, probe them, then remove them again
        fill_n = 200;
        for (k = 0; k < fill_n; k++)
            send_request(make_req(REQ_ADD, {20'($urandom_range(0, 255)), 12'(k * 3)},
                                  0, $urandom(), 0));
        send_request(make_req(REQ_ADD, 32'h0000_0001, 0, 0, 0));
        send_request(make_req(REQ_ADD_IF, 32'h0000_0003, 0, 0, 0));
        send_request(make_req(REQ_READ, 0, 0, 0, 10'h3FF));
        wait_drained();
        for (k = 0; k < fill_n; k++)
            send_request(make_req(REQ_REMOVE, 32'(k * 3 % MAP_DEPTH), 0, 0, 0));
        known_handles.delete();
        wait_drained();
    endtask

    task automatic test_random(int unsigned n);
        int unsigned k, burst;
        t_req q;
        k = 0;
        while (k < n) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                q.req_type = $urandom_range(0, 9) < 4 ? 3'($urandom_range(0, 1))
                                                      : 3'($urandom_range(0, 7));
                q.entity = pick_handle();
                q.entity_second = pick_handle();
                q.value = $urandom();
                q.position = $urandom_range(0, 1) ? 10'($urandom_range(0, live_count + 2))
                                                  : 10'($urandom());
                send_request(q);
                k++;
            end
            if ($urandom_range(0, 2) == 0) idle_request($urandom_range(1, 8));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        int unsigned k;
        hold_rsp = 1'b1;
        for (k = 0; k < 20; k++)
            send_request(make_req(REQ_GET, pick_handle(), 0, 0, 0));
        wait_drained();
    endtask

    // long receiver hold-off counted in cycles
    initial begin
        int unsigned c;
        forever begin
            wait (hold_rsp);
            for (c = 0; c < 300; c++) @(posedge i_clk);
            hold_rsp = 1'b0;
        end
    end

    // receiver stall pattern
    initial begin
        int unsigned phase;
        rsp_ch.ready <= 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_rsp)
                rsp_ch.ready <= 1'b0;
            else if ((phase / 200) % 3 == 0)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response %h", rsp_ch.payload);
            end else begin
                exp_r = expected_rsps.pop_front();
                if (rsp_ch.payload !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st=%0d ix=%0d val=%h ent=%h n=%0d,",
                                 exp_r.status, exp_r.dense_index, exp_r.value_out,
                                 exp_r.entity_out, exp_r.live_entries,
                                 " got st=%0d ix=%0d val=%h ent=%h n=%0d",
                                 rsp_ch.payload.status, rsp_ch.payload.dense_index,
                                 rsp_ch.payload.value_out, rsp_ch.payload.entity_out,
                                 rsp_ch.payload.live_entries);
                end
            end
        end
    end

    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        hold_rsp       = 1'b0;
        mismatch_count = 0;
        live_count     = 0;
        foreach (map_live[k]) map_live[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(130);
        test_fill_table();
        test_random(130);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
